// File: hdl/sea_pkg.sv
// Shared types and constants of the price averager.
// Used by the output interface, the arithmetic unit and the top level.
package sea_pkg;

  localparam int Q_BITS      = 8;   // fraction bits of the Q24.8 outputs
  localparam int WEIGHT_BITS = 16;  // alpha in Q0.16
  localparam int OUT_BITS    = 32;
  localparam int WLEN_BITS   = 7;
  localparam int CFG_BITS    = 16;

  localparam logic [WLEN_BITS-1:0]   WLEN_RESET   = 7'd10;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd11916;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_EMA_WEIGHT    = 1'b1
  } cfg_reg_t;

  // Operations of the shared iterative unit
  typedef enum logic [0:0] {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

endpackage

// File: hdl/sea_in_if.sv
// Input channel of the price averager: one price sample per word.
// Standalone; width follows PRICE_BITS.
interface sea_in_if #(
  parameter int PRICE_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

// File: hdl/sea_out_if.sv
// Result channel of the price averager: SMA and EMA per word.
// Depends on sea_pkg for the output width.
interface sea_out_if import sea_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                sma_valid;
  logic [OUT_BITS-1:0] sma_value;
  logic                ema_valid;
  logic [OUT_BITS-1:0] ema_value;

  modport source (output valid, output sma_valid, output sma_value,
                  output ema_valid, output ema_value, input ready);
  modport sink   (input valid, input sma_valid, input sma_value,
                  input ema_valid, input ema_value, output ready);
endinterface

// File: hdl/sea_ring.sv
// Sample ring memory: one write port, one registered read port.
// Standalone; read returns the old data on a same-address write.
module sea_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [PW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [PW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first, then write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// File: hdl/sea_arith.sv
// Shared iterative unit: restoring divide by the window length (one
// quotient bit a cycle) and shift-add multiply by alpha (one weight bit a
// cycle, result taken >> 16). Depends on sea_pkg.
module sea_arith import sea_pkg::*; #(
  parameter int AW = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  arith_ctl_t             ctl,
  input  logic [AW-1:0]          opnd_a,
  input  logic [WLEN_BITS-1:0]   divisor,
  input  logic [WEIGHT_BITS-1:0] weight,
  output logic                   done,
  output logic [AW-1:0]          res
);

  localparam int CNTW = $clog2(AW);
  localparam int PW   = AW + WEIGHT_BITS;

  logic                   busy;
  arith_op_t              op;
  logic [CNTW-1:0]        cnt;
  logic [AW-1:0]          work;
  logic [WLEN_BITS-1:0]   rem;
  logic [AW-1:0]          mcand;
  logic [PW-1:0]          acc;
  logic [WEIGHT_BITS-1:0] wsh;

  logic [WLEN_BITS:0]     trial;
  logic                   fits;
  logic [WLEN_BITS:0]     trial_sub;
  logic                   last;

  // Divide step: shift one dividend bit into the remainder
  always_comb begin
    trial     = {rem, work[AW-1]};
    fits      = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
    if (op == OP_DIV) begin
      last = cnt == CNTW'(AW - 1);
    end else begin
      last = cnt == CNTW'(WEIGHT_BITS - 1);
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op    <= ctl.op;
      cnt   <= '0;
      work  <= opnd_a;
      rem   <= '0;
      mcand <= opnd_a;
      acc   <= '0;
      wsh   <= weight;
    end else if (busy) begin
      cnt <= cnt + CNTW'(1);
      if (op == OP_DIV) begin
        work <= {work[AW-2:0], fits};
        rem  <= fits ? trial_sub[WLEN_BITS-1:0] : trial[WLEN_BITS-1:0];
      end else begin
        acc <= {acc[PW-2:0], 1'b0} + (wsh[WEIGHT_BITS-1] ? PW'(mcand) : '0);
        wsh <= {wsh[WEIGHT_BITS-2:0], 1'b0};
      end
    end
  end

  assign res = (op == OP_DIV) ? work : acc[PW-1:WEIGHT_BITS];

endmodule

// File: hdl/sma_ema_price_averager_unit.sv
// Simple and exponential moving average of a price stream, Q24.8 outputs.
// Full-window sample: AW divide steps and 16 multiply steps on the shared unit, with
// AW = max(PRICE_BITS+15, 32) + 1 = 40 at defaults. Seeding sample: the divide steps only;
// window not yet full: no arithmetic. A new sample is taken only once the last is through the
// sequencer. A finished word waits in the output register while the next sample is taken;
// a stalled sink holds the next word back. Synchronous reset clears the averager.
module sma_ema_price_averager_unit import sea_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  sea_in_if.sink                sample,
  sea_out_if.source             result
);

  localparam int PTRW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AXW  = ((PTRW > WLEN_BITS) ? PTRW : WLEN_BITS) + 1;
  localparam int SW   = PRICE_BITS + WLEN_BITS;
  localparam int DW   = SW + Q_BITS;
  localparam int TW   = PRICE_BITS + Q_BITS;
  localparam int AW0  = (DW > TW) ? DW : TW;
  localparam int AW   = ((AW0 > OUT_BITS) ? AW0 : OUT_BITS) + 1;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SUB       = 7'b0000010,
    S_DIV_START = 7'b0000100,
    S_DIV_WAIT  = 7'b0001000,
    S_DIFF      = 7'b0010000,
    S_MUL_WAIT  = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t                 state;
  logic [WLEN_BITS-1:0]   window_length;
  logic [WEIGHT_BITS-1:0] ema_weight;
  logic [PRICE_BITS-1:0]  price;
  logic                   was_full;
  logic                   full;
  logic                   up;
  logic [SW-1:0]          window_sum;
  logic [PTRW-1:0]        write_pointer;
  logic [WLEN_BITS-1:0]   samples_seen;
  logic [OUT_BITS-1:0]    ema_register;
  logic [OUT_BITS-1:0]    sma;

  logic                   res_valid;
  logic                   res_full;
  logic [OUT_BITS-1:0]    res_sma;
  logic [OUT_BITS-1:0]    res_ema;

  logic                   accept;
  logic [WLEN_BITS-1:0]   eff_n;
  logic [AXW-1:0]         wp_x;
  logic [AXW-1:0]         n_x;
  logic [AXW-1:0]         old_x;
  logic [PTRW-1:0]        wp_next;
  logic [WLEN_BITS-1:0]   seen_next;
  logic [PRICE_BITS-1:0]  old_price;
  logic [AW-1:0]          target;
  logic [AW-1:0]          ema_x;
  logic                   ge;
  logic [AW-1:0]          diff;
  logic [AW-1:0]          up_sum;
  arith_ctl_t             actl;
  logic [AW-1:0]          opnd_a;
  logic                   adone;
  logic [AW-1:0]          ares;

  assign accept = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);

  // Effective window: zero reads as one, clamp to the ring depth
  always_comb begin
    if (window_length == '0) begin
      eff_n = WLEN_BITS'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      eff_n = WLEN_BITS'(MAX_WINDOW);
    end else begin
      eff_n = window_length;
    end
  end

  // Ring addresses: slot leaving the window and the next write slot
  always_comb begin
    wp_x = AXW'(write_pointer);
    n_x  = AXW'(eff_n);
    if (wp_x >= n_x) begin
      old_x = wp_x - n_x;
    end else begin
      old_x = wp_x + AXW'(MAX_WINDOW) - n_x;
    end
    if (write_pointer == PTRW'(MAX_WINDOW - 1)) begin
      wp_next = '0;
    end else begin
      wp_next = write_pointer + PTRW'(1);
    end
    seen_next = (samples_seen >= eff_n) ? samples_seen : samples_seen + WLEN_BITS'(1);
  end

  sea_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (PRICE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (write_pointer),
    .wdata (sample.price),
    .re    (accept),
    .raddr (old_x[PTRW-1:0]),
    .rdata (old_price)
  );

  // EMA difference and update terms
  always_comb begin
    target = AW'({price, {Q_BITS{1'b0}}});
    ema_x  = AW'(ema_register);
    ge     = target >= ema_x;
    diff   = ge ? target - ema_x : ema_x - target;
    up_sum = ema_x + ares;
  end

  // Drive the shared unit
  always_comb begin
    actl.start = (state == S_DIV_START) || (state == S_DIFF);
    actl.op    = (state == S_DIFF) ? OP_MUL : OP_DIV;
    opnd_a     = (state == S_DIFF) ? diff : AW'({window_sum, {Q_BITS{1'b0}}});
  end

  sea_arith #(
    .AW (AW)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .ctl     (actl),
    .opnd_a  (opnd_a),
    .divisor (eff_n),
    .weight  (ema_weight),
    .done    (adone),
    .res     (ares)
  );

  // Sequencer and averager state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WLEN_RESET;
      ema_weight    <= WEIGHT_RESET;
      window_sum    <= '0;
      write_pointer <= '0;
      samples_seen  <= '0;
      ema_register  <= '0;
      res_valid     <= 1'b0;
    end else begin
      // Configuration writes; a window write restarts the averager
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[WLEN_BITS-1:0];
            window_sum    <= '0;
            write_pointer <= '0;
            samples_seen  <= '0;
            ema_register  <= '0;
          end
          REG_EMA_WEIGHT: begin
            ema_weight <= cfg_data[WEIGHT_BITS-1:0];
          end
          default: begin
          end
        endcase
      end

      // Load a finished word, or drop the one the sink has taken
      if ((state == S_FINISH) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            price         <= sample.price;
            was_full      <= samples_seen >= eff_n;
            full          <= seen_next >= eff_n;
            window_sum    <= window_sum + SW'(sample.price);
            write_pointer <= wp_next;
            samples_seen  <= seen_next;
            state         <= S_SUB;
          end
        end
        S_SUB: begin
          // Drop the sample that leaves the window
          if (was_full) begin
            window_sum <= window_sum - SW'(old_price);
          end
          state <= full ? S_DIV_START : S_FINISH;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (adone) begin
            sma <= (|ares[AW-1:OUT_BITS]) ? '1 : ares[OUT_BITS-1:0];
            if (was_full) begin
              state <= S_DIFF;
            end else begin
              ema_register <= (|ares[AW-1:OUT_BITS]) ? '1 : ares[OUT_BITS-1:0];
              state        <= S_FINISH;
            end
          end
        end
        S_DIFF: begin
          up    <= ge;
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (adone) begin
            if (up) begin
              ema_register <= (|up_sum[AW-1:OUT_BITS]) ? '1 : up_sum[OUT_BITS-1:0];
            end else begin
              ema_register <= ema_register - ares[OUT_BITS-1:0];
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hand the word over once the output register is free
          if (!res_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!res_valid || result.ready)) begin
      res_full <= full;
      res_sma  <= full ? sma : '0;
      res_ema  <= full ? ema_register : '0;
    end
  end

  assign result.valid     = res_valid;
  assign result.sma_valid = res_full;
  assign result.sma_value = res_sma;
  assign result.ema_valid = res_full;
  assign result.ema_value = res_ema;

endmodule
